>>> rtl/core/mhp_pkg.sv
package mhp_pkg;

	typedef enum logic [2:0] {
		ROLE_NAME_LEN     = 3'd0,
		ROLE_MOD_NAME     = 3'd1,
		ROLE_EXP_COUNT    = 3'd2,
		ROLE_EXP_NAME_LEN = 3'd3,
		ROLE_EXP_NAME     = 3'd4,
		ROLE_OFFSET_LO    = 3'd5,
		ROLE_OFFSET_HI    = 3'd6,
		ROLE_CODE         = 3'd7
	} role_t;

	localparam logic [1:0] STATUS_NONE      = 2'd0;
	localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic        entry_valid;
		logic [7:0]  export_index;
		logic [15:0] export_offset;
		logic [1:0]  end_status;
		logic [15:0] code_start;
	} out_item_t;

endpackage

>>> rtl/core/module_header_parser_unit.sv
// A byte's result passes through the queue and then the output register before it
// is offered, and is taken at a rising edge when the result side is ready.
// One byte is accepted per cycle while the result side keeps up; the parser
// state updates on each accepted byte and a two-entry queue feeds the output register.
// Reset (arst_n low) returns the parser to expecting the module name length,
// clears the position count and empties the queue and output register.
module module_header_parser_unit #(
	parameter int POSITION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  mhp_pkg::in_item_t  byte_data,
	output logic               result_valid,
	input  logic               result_ready,
	output mhp_pkg::out_item_t result_data
);
	import mhp_pkg::*;

	logic      take;
	out_item_t front_result;
	out_item_t queue_data;
	logic      queue_full;
	logic      queue_empty;
	logic      queue_pop;

	assign byte_ready = !queue_full;
	assign take       = byte_valid && byte_ready;

	mhp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (byte_data),
		.result (front_result)
	);

	mhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_result),
		.pop       (queue_pop),
		.pop_data  (queue_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	mhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.queue_data   (queue_data),
		.queue_pop    (queue_pop),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

>>> rtl/core/mhp_front.sv
module mhp_front #(
	parameter int POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  mhp_pkg::in_item_t item,
	output mhp_pkg::out_item_t result
);
	import mhp_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	role_t                    phase_q, phase_n;
	logic [7:0]               bytes_left_q, bytes_left_n;
	logic [7:0]               exports_left_q, exports_left_n;
	logic [7:0]               export_counter_q, export_counter_n;
	logic [7:0]               offset_low_q, offset_low_n;
	logic [POSITION_BITS-1:0] position_q, position_n;
	logic [POSITION_BITS-1:0] code_start_q, code_start_n;
	logic [POSITION_BITS+15:0] code_start_ext;
	logic                     finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= ROLE_NAME_LEN;
			bytes_left_q     <= '0;
			exports_left_q   <= '0;
			export_counter_q <= '0;
			offset_low_q     <= '0;
			position_q       <= '0;
			code_start_q     <= '0;
		end else if (take) begin
			phase_q          <= phase_n;
			bytes_left_q     <= bytes_left_n;
			exports_left_q   <= exports_left_n;
			export_counter_q <= export_counter_n;
			offset_low_q     <= offset_low_n;
			position_q       <= position_n;
			code_start_q     <= code_start_n;
		end
	end

	always_comb begin
		phase_n          = phase_q;
		bytes_left_n     = bytes_left_q;
		exports_left_n   = exports_left_q;
		export_counter_n = export_counter_q;
		offset_low_n     = offset_low_q;
		code_start_n     = code_start_q;
		finish           = 1'b0;
		result           = '0;
		result.byte_role = phase_q;

		unique case (phase_q)
			ROLE_NAME_LEN: begin
				bytes_left_n = item.byte_value;
				phase_n = (item.byte_value != 8'd0) ? ROLE_MOD_NAME : ROLE_EXP_COUNT;
			end
			ROLE_MOD_NAME: begin
				bytes_left_n = 8'(bytes_left_q - 8'd1);
				if (bytes_left_n == 8'd0) begin
					phase_n = ROLE_EXP_COUNT;
				end
			end
			ROLE_EXP_COUNT: begin
				exports_left_n   = item.byte_value;
				export_counter_n = '0;
				if (item.byte_value != 8'd0) begin
					phase_n = ROLE_EXP_NAME_LEN;
				end else begin
					finish = 1'b1;
				end
			end
			ROLE_EXP_NAME_LEN: begin
				result.export_index = export_counter_q;
				bytes_left_n = item.byte_value;
				phase_n = (item.byte_value != 8'd0) ? ROLE_EXP_NAME : ROLE_OFFSET_LO;
			end
			ROLE_EXP_NAME: begin
				result.export_index = export_counter_q;
				bytes_left_n = 8'(bytes_left_q - 8'd1);
				if (bytes_left_n == 8'd0) begin
					phase_n = ROLE_OFFSET_LO;
				end
			end
			ROLE_OFFSET_LO: begin
				result.export_index = export_counter_q;
				offset_low_n = item.byte_value;
				phase_n = ROLE_OFFSET_HI;
			end
			ROLE_OFFSET_HI: begin
				result.export_index  = export_counter_q;
				result.entry_valid   = 1'b1;
				result.export_offset = {item.byte_value, offset_low_q};
				exports_left_n   = 8'(exports_left_q - 8'd1);
				export_counter_n = 8'(export_counter_q + 8'd1);
				if (exports_left_n == 8'd0) begin
					finish = 1'b1;
				end else begin
					phase_n = ROLE_EXP_NAME_LEN;
				end
			end
			ROLE_CODE: begin
				phase_n = ROLE_CODE;
			end
		endcase

		if (finish) begin
			phase_n      = ROLE_CODE;
			code_start_n = position_q + POS_ONE;
		end
		position_n     = position_q + POS_ONE;
		code_start_ext = {16'd0, code_start_n};

		if (item.is_last) begin
			if (phase_n == ROLE_CODE) begin
				result.end_status = STATUS_COMPLETE;
				result.code_start = code_start_ext[15:0];
			end else begin
				result.end_status = STATUS_TRUNCATED;
			end
			phase_n          = ROLE_NAME_LEN;
			bytes_left_n     = '0;
			exports_left_n   = '0;
			export_counter_n = '0;
			offset_low_n     = '0;
			position_n       = '0;
			code_start_n     = '0;
		end
	end

endmodule

>>> rtl/core/mhp_queue.sv
module mhp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mhp_pkg::out_item_t push_data,
	input  logic               pop,
	output mhp_pkg::out_item_t pop_data,
	output logic               full,
	output logic               empty
);
	import mhp_pkg::*;

	out_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);

endmodule

>>> rtl/core/mhp_back.sv
module mhp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_empty,
	input  mhp_pkg::out_item_t queue_data,
	output logic               queue_pop,
	input  logic               result_ready,
	output logic               result_valid,
	output mhp_pkg::out_item_t result_data
);
	import mhp_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign queue_pop = !queue_empty && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result_ready) begin
			valid_q <= !queue_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (queue_pop) begin
			data_q <= queue_data;
		end
	end

	assign result_valid = valid_q;
	assign result_data  = data_q;

endmodule

>>> rtl/core/mhp_checker.sv
module mhp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input logic               byte_ready,
	input logic               result_valid,
	input logic               result_ready,
	input mhp_pkg::out_item_t result_data
);
	import mhp_pkg::*;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("Stalled result transaction changed or dropped.");

	a_entry_on_offset_high: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.entry_valid |->
			result_data.byte_role == ROLE_OFFSET_HI)
		else $error("Export entry reported on a byte other than the offset high byte.");

	a_offset_only_with_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.entry_valid |-> result_data.export_offset == 16'd0)
		else $error("Export offset set without a completed entry.");

	a_code_start_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.end_status != STATUS_COMPLETE |->
			result_data.code_start == 16'd0)
		else $error("Code start given without a complete header.");

	a_no_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && byte_ready, 2))
		else $error("Result transaction appeared without an accepted byte.");

endmodule

bind module_header_parser_unit mhp_checker u_mhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);
